@@ hdl/lidar_obstacle_speed_governor_core_macros.svh @@
// Assertion macros for the lidar obstacle speed governor.
`ifndef LIDAR_OBSTACLE_SPEED_GOVERNOR_CORE_MACROS_SVH
`define LIDAR_OBSTACLE_SPEED_GOVERNOR_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define LOSG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("losg assertion failed");

// next-cycle implication, disabled in reset
`define LOSG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("losg assertion failed");

`endif

@@ hdl/losg_pkg.sv @@
// Shared types and constants for the lidar obstacle speed governor.
package losg_pkg;

    localparam int MAX_SAMPLES       = 4096;
    localparam int WINDOW_HALF_ANGLE = 549033;

    localparam int RANGE_W  = 16;
    localparam int SPEED_W  = 16;
    localparam int START_W  = 24;
    localparam int STEP_W   = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int IDX_W   = $clog2(MAX_SAMPLES);
    localparam int PROD_W  = IDX_W + STEP_W;
    localparam int ANGLE_W = PROD_W + 2;

    localparam int DIV_W     = 2 * RANGE_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [RANGE_W-1:0] NO_RETURN = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DISTANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH    = 3'd6;

    // register reset values
    localparam logic [SPEED_W-1:0]        RST_MAX_SPEED     = 16'd500;
    localparam logic [RANGE_W-1:0]        RST_SLOW_DISTANCE = 16'd610;
    localparam logic [RANGE_W-1:0]        RST_STOP_DISTANCE = 16'd305;
    localparam logic signed [START_W-1:0] RST_ANGLE_START   = -24'sd3294199;
    localparam logic [STEP_W-1:0]         RST_ANGLE_STEP    = 21'd6100;
    localparam logic [RANGE_W-1:0]        RST_RANGE_LOW     = 16'd100;
    localparam logic [RANGE_W-1:0]        RST_RANGE_HIGH    = 16'd12000;

    typedef enum logic [1:0] {
        DEC_NONE = 2'd0,
        DEC_STOP = 2'd1,
        DEC_SLOW = 2'd2,
        DEC_FULL = 2'd3
    } decision_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               last_sample;
    } sample_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_cmd;
        decision_t          decision;
        logic [RANGE_W-1:0] nearest_mm;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_SPD,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic update;
        logic speed;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic slow;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

@@ hdl/losg_ctrl.sv @@
// Sequencing state machine for the lidar obstacle speed governor.
module losg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  losg_pkg::dp_status_t  status,
    output losg_pkg::dp_cmd_t     cmd
);

    losg_pkg::state_t state_reg;
    losg_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= losg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            losg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = losg_pkg::ST_MUL;
                end
            end
            losg_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = losg_pkg::ST_UPD;
            end
            losg_pkg::ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = status.last ? losg_pkg::ST_SPD : losg_pkg::ST_IDLE;
            end
            losg_pkg::ST_SPD:
            begin
                cmd.speed  = 1'b1;
                state_next = status.slow ? losg_pkg::ST_DIV : losg_pkg::ST_DONE;
            end
            losg_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = losg_pkg::ST_DONE;
                end
            end
            losg_pkg::ST_DONE:
            begin
                // wait until the output register can take the result
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = losg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = losg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/losg_dp.sv @@
// Datapath: config registers, angle window, nearest tracking, divider, output register.
module losg_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [losg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [losg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  losg_pkg::sample_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output losg_pkg::result_t                   out_data,
    input  losg_pkg::dp_cmd_t                   cmd,
    output losg_pkg::dp_status_t                status
);

    localparam int RW = losg_pkg::RANGE_W;
    localparam int AW = losg_pkg::ANGLE_W;
    localparam logic signed [AW-1:0] WIN_HI = AW'(losg_pkg::WINDOW_HALF_ANGLE);
    localparam logic signed [AW-1:0] WIN_LO = -WIN_HI;
    localparam logic [losg_pkg::IDX_W-1:0] IDX_MAX =
        losg_pkg::IDX_W'(losg_pkg::MAX_SAMPLES - 1);
    localparam logic [losg_pkg::DIV_CNT_W-1:0] DIV_LAST =
        losg_pkg::DIV_CNT_W'(losg_pkg::DIV_W - 1);

    // configuration
    logic [losg_pkg::SPEED_W-1:0]        max_speed_reg;
    logic [RW-1:0]                       slow_dist_reg;
    logic [RW-1:0]                       stop_dist_reg;
    logic signed [losg_pkg::START_W-1:0] angle_start_reg;
    logic [losg_pkg::STEP_W-1:0]         angle_step_reg;
    logic [RW-1:0]                       range_low_reg;
    logic [RW-1:0]                       range_high_reg;

    // scan state
    logic [losg_pkg::IDX_W-1:0] idx_reg;
    logic [RW-1:0]              nearest_reg;
    logic                       found_reg;

    // working registers
    logic [RW-1:0]                  range_reg;
    logic                           last_reg;
    logic [losg_pkg::PROD_W-1:0]    prod_reg;
    losg_pkg::decision_t            dec_reg;
    logic [losg_pkg::DIV_W-1:0]     quot_reg;
    logic [RW-1:0]                  rem_reg;
    logic [RW-1:0]                  den_reg;
    logic [losg_pkg::DIV_CNT_W-1:0] cnt_reg;

    logic              out_valid_reg;
    losg_pkg::result_t out_data_reg;

    logic signed [AW-1:0] angle;
    logic                 in_window;
    logic                 range_ok;
    logic                 take;
    losg_pkg::decision_t  dec_next;
    logic [RW:0]          trial;
    logic                 trial_ge;
    logic [losg_pkg::SPEED_W-1:0] speed_sel;

    always_comb
    begin
        angle = AW'(angle_start_reg) + $signed({2'b00, prod_reg});
        in_window = (angle >= WIN_LO) && (angle <= WIN_HI);
        range_ok  = (range_reg != losg_pkg::NO_RETURN) && (range_reg >= range_low_reg)
                    && (range_reg <= range_high_reg);
        take      = in_window && range_ok && (!found_reg || (range_reg < nearest_reg));

        if (!found_reg)
        begin
            dec_next = losg_pkg::DEC_NONE;
        end
        else if (nearest_reg <= stop_dist_reg)
        begin
            dec_next = losg_pkg::DEC_STOP;
        end
        else if (nearest_reg <= slow_dist_reg)
        begin
            dec_next = losg_pkg::DEC_SLOW;
        end
        else
        begin
            dec_next = losg_pkg::DEC_FULL;
        end

        // restoring division, one quotient bit per cycle
        trial    = {rem_reg, quot_reg[losg_pkg::DIV_W-1]};
        trial_ge = trial >= {1'b0, den_reg};

        case (dec_reg)
            losg_pkg::DEC_SLOW: speed_sel = quot_reg[losg_pkg::SPEED_W-1:0];
            losg_pkg::DEC_FULL: speed_sel = max_speed_reg;
            default:            speed_sel = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg   <= losg_pkg::RST_MAX_SPEED;
            slow_dist_reg   <= losg_pkg::RST_SLOW_DISTANCE;
            stop_dist_reg   <= losg_pkg::RST_STOP_DISTANCE;
            angle_start_reg <= losg_pkg::RST_ANGLE_START;
            angle_step_reg  <= losg_pkg::RST_ANGLE_STEP;
            range_low_reg   <= losg_pkg::RST_RANGE_LOW;
            range_high_reg  <= losg_pkg::RST_RANGE_HIGH;
            idx_reg         <= '0;
            nearest_reg     <= losg_pkg::NO_RETURN;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    losg_pkg::CFG_MAX_SPEED:     max_speed_reg   <= cfg_data[15:0];
                    losg_pkg::CFG_SLOW_DISTANCE: slow_dist_reg   <= cfg_data[15:0];
                    losg_pkg::CFG_STOP_DISTANCE: stop_dist_reg   <= cfg_data[15:0];
                    losg_pkg::CFG_ANGLE_START:   angle_start_reg <= $signed(cfg_data);
                    losg_pkg::CFG_ANGLE_STEP:    angle_step_reg  <= cfg_data[20:0];
                    losg_pkg::CFG_RANGE_LOW:     range_low_reg   <= cfg_data[15:0];
                    losg_pkg::CFG_RANGE_HIGH:    range_high_reg  <= cfg_data[15:0];
                    default:                     ;
                endcase
            end

            if (cmd.update)
            begin
                if (take)
                begin
                    nearest_reg <= range_reg;
                    found_reg   <= 1'b1;
                end
                if (idx_reg < IDX_MAX)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= '0;
                nearest_reg   <= losg_pkg::NO_RETURN;
                found_reg     <= 1'b0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            range_reg <= in_data.range_mm;
            last_reg  <= in_data.last_sample;
        end
        if (cmd.mul)
        begin
            prod_reg <= idx_reg * angle_step_reg;
        end
        if (cmd.speed)
        begin
            dec_reg  <= dec_next;
            quot_reg <= max_speed_reg * (nearest_reg - stop_dist_reg);
            den_reg  <= slow_dist_reg - stop_dist_reg;
            rem_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= trial_ge ? RW'(trial - {1'b0, den_reg}) : trial[RW-1:0];
            quot_reg <= {quot_reg[losg_pkg::DIV_W-2:0], trial_ge};
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            out_data_reg.speed_cmd  <= speed_sel;
            out_data_reg.decision   <= dec_reg;
            out_data_reg.nearest_mm <= nearest_reg;
        end
    end

    assign status.last     = last_reg;
    assign status.slow     = (dec_next == losg_pkg::DEC_SLOW);
    assign status.div_done = (cnt_reg == DIV_LAST);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hdl/lidar_obstacle_speed_governor_core.sv @@
// A sample that is not last holds in_ready low through the ST_MUL and ST_UPD states after acceptance.
// A last sample goes on to ST_SPD, then to ST_DIV for a slow-down decision, and then to ST_DONE;
// in ST_DIV a 32-step restoring divider forms the speed one quotient bit per cycle.
// A new sample is taken only back in ST_IDLE, after the angle multiply and window compare steps.
// The output register lets the next scan start while a result waits to be taken.
// Reset (rst_n, async, active low): registers to defaults, scan state cleared, no result pending.
module lidar_obstacle_speed_governor_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [losg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [losg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  losg_pkg::sample_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output losg_pkg::result_t               out_data
);

    losg_pkg::dp_cmd_t    cmd;
    losg_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    losg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    losg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

`include "lidar_obstacle_speed_governor_core_macros.svh"

    // one request at a time: busy right after acceptance
    `LOSG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // an empty window reports no range and no speed
    `LOSG_ASSERT_NOW(a_none_result, out_valid && (out_data.decision == losg_pkg::DEC_NONE),
        (out_data.nearest_mm == losg_pkg::NO_RETURN) && (out_data.speed_cmd == '0))
    // a stop carries zero speed
    `LOSG_ASSERT_NOW(a_stop_result, out_valid && (out_data.decision == losg_pkg::DEC_STOP),
        out_data.speed_cmd == '0)

endmodule
